// ===== sv/skht_pkg.sv =====
// ----------------------------------------------------------------------------
// skht_pkg
// Shared types and constants for the sorted key / handle table.
// ----------------------------------------------------------------------------
`default_nettype none

package skht_pkg;

  localparam int CAPACITY    = 32;
  localparam int HANDLE_BITS = 32;
  localparam int MAX_RUN     = 32;
  localparam int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW          = $clog2(CAPACITY + 1);
  localparam int IW          = 7;

  // opcodes
  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_CHECK   = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_EXTRACT = 3'd3;
  localparam logic [2:0] OP_SHIFT   = 3'd4;
  localparam logic [2:0] OP_DELETE  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_OOB   = 2'd2;
  localparam logic [1:0] ST_BELOW = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] shift_amount;
    logic [31:0] handle_in;
    logic [6:0]  cursor_in;
    logic [5:0]  entry_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [6:0]  cursor_out;
    logic [31:0] key_out;
    logic [31:0] handle_out;
    logic [6:0]  entry_count;
    logic        last;
  } out_word_t;

  // store write request
  typedef struct packed {
    logic                   key_we;
    logic                   hnd_we;
    logic [AW-1:0]          addr;
    logic [31:0]            key;
    logic [HANDLE_BITS-1:0] hnd;
  } wr_req_t;

endpackage

`default_nettype wire

// ===== sv/skht_store.sv =====
// ----------------------------------------------------------------------------
// skht_store
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skht_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/sorted_key_handle_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_handle_table_top
// Ascending key table with handles, run by a sequencer over one store port.
// ----------------------------------------------------------------------------
// Store reads are registered, so each table step has an address phase and a data phase.
// Extract emits its words one per handshake, then closes the removed span.
// One word in flight: the next word is accepted only after the last result is taken.
// Synchronous active-low reset empties the table; store contents stay.
`default_nettype none

module sorted_key_handle_table_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire skht_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output skht_pkg::out_word_t      out_data
);

  localparam int AW = skht_pkg::AW;
  localparam int CW = skht_pkg::CW;
  localparam int IW = skht_pkg::IW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LB      = 4'd1;
  localparam logic [3:0] S_INS     = 4'd2;
  localparam logic [3:0] S_CHECK   = 4'd3;
  localparam logic [3:0] S_SCAN_SH = 4'd4;
  localparam logic [3:0] S_APPLY   = 4'd5;
  localparam logic [3:0] S_SCAN_DL = 4'd6;
  localparam logic [3:0] S_EMIT    = 4'd7;
  localparam logic [3:0] S_EWAIT   = 4'd8;
  localparam logic [3:0] S_COMPACT = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;
  localparam logic [3:0] S_RD      = 4'd11;

  logic [3:0]  st_r, st_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [31:0] ka_r, ka_nxt, kb_r, kb_nxt, sa_r, sa_nxt;
  logic [skht_pkg::HANDLE_BITS-1:0] hin_r, hin_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt, lo_r, lo_nxt, n_r, n_nxt;
  logic [IW-1:0] left_r, left_nxt, right_r, right_nxt;
  logic        left_v_r, left_v_nxt, right_v_r, right_v_nxt, sel_r, sel_nxt;
  logic        ph_r, ph_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic        out_valid_r, out_valid_nxt;
  skht_pkg::out_word_t out_r, out_nxt;

  skht_pkg::wr_req_t wr;
  logic [IW-1:0] rd_idx;
  logic [31:0]   rd_key;
  logic [skht_pkg::HANDLE_BITS-1:0] rd_hnd;

  logic [IW-1:0] fill_w;
  logic [IW-1:0] span;
  logic [31:0]   lb_key;
  logic          in_fire, out_fire, lt_delta;

  assign in_ready  = (st_r == S_IDLE) && !out_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_fire  = out_valid_r && out_ready;
  assign out_data  = out_r;
  assign fill_w    = IW'(fill_r);
  assign lb_key    = sel_r ? kb_r : ka_r;
  assign lt_delta  = $signed({1'b0, rd_key}) < $signed({sa_r[31], sa_r});

  skht_store #(.WIDTH(32), .DEPTH(skht_pkg::CAPACITY)) u_key_store (
    .clk   (clk),
    .we    (wr.key_we),
    .waddr (wr.addr),
    .wdata (wr.key),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_key)
  );

  skht_store #(.WIDTH(skht_pkg::HANDLE_BITS), .DEPTH(skht_pkg::CAPACITY)) u_hnd_store (
    .clk   (clk),
    .we    (wr.hnd_we),
    .waddr (wr.addr),
    .wdata (wr.hnd),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_hnd)
  );

  // read address select
  always_comb begin
    unique case (st_r)
      S_IDLE:    rd_idx = IW'(in_data.entry_index);
      S_INS:     rd_idx = j_r - IW'(1);
      S_EMIT:    rd_idx = lo_r + j_r;
      S_COMPACT: rd_idx = i_r + n_r;
      default:   rd_idx = i_r;
    endcase
  end

  // sequencer, read states present the address and use the registered data in the next cycle
  always_comb begin
    st_nxt        = st_r;
    op_nxt        = op_r;
    ka_nxt        = ka_r;
    kb_nxt        = kb_r;
    sa_nxt        = sa_r;
    hin_nxt       = hin_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    n_nxt         = n_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    left_v_nxt    = left_v_r;
    right_v_nxt   = right_v_r;
    sel_nxt       = sel_r;
    ph_nxt        = ph_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    span          = '0;
    wr            = '0;
    wr.addr       = i_r[AW-1:0];
    wr.key        = rd_key;
    wr.hnd        = rd_hnd;

    if (out_fire) out_valid_nxt = 1'b0;

    unique case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_data.opcode;
          ka_nxt      = in_data.key_a;
          kb_nxt      = in_data.key_b;
          sa_nxt      = in_data.shift_amount;
          hin_nxt     = in_data.handle_in[skht_pkg::HANDLE_BITS-1:0];
          i_nxt       = '0;
          sel_nxt     = 1'b0;
          ph_nxt      = 1'b0;
          left_v_nxt  = 1'b0;
          right_v_nxt = 1'b0;
          out_nxt     = '0;
          out_nxt.last        = 1'b1;
          out_nxt.entry_count = fill_w;
          unique case (in_data.opcode)
            skht_pkg::OP_INSERT: begin
              if (fill_w >= IW'(skht_pkg::CAPACITY)) begin
                out_nxt.status = skht_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
                st_nxt         = S_DONE;
              end else begin
                st_nxt = S_LB;
              end
            end
            skht_pkg::OP_CHECK: begin
              i_nxt = in_data.cursor_in;
              if (in_data.cursor_in < fill_w) begin
                st_nxt = S_CHECK;
              end else begin
                out_nxt.cursor_out = in_data.cursor_in;
                out_valid_nxt      = 1'b1;
                st_nxt             = S_DONE;
              end
            end
            skht_pkg::OP_READ: begin
              if (IW'(in_data.entry_index) >= fill_w) begin
                out_nxt.status = skht_pkg::ST_OOB;
                out_valid_nxt  = 1'b1;
                st_nxt         = S_DONE;
              end else begin
                st_nxt = S_RD;
              end
            end
            skht_pkg::OP_EXTRACT: st_nxt = S_LB;
            skht_pkg::OP_SHIFT:   st_nxt = S_SCAN_SH;
            skht_pkg::OP_DELETE:  st_nxt = S_SCAN_DL;
            default: begin
              out_valid_nxt = 1'b1;
              st_nxt        = S_DONE;
            end
          endcase
        end
      end

      // handle read, address was taken at acceptance
      S_RD: begin
        out_nxt.handle_out = 32'(rd_hnd);
        out_valid_nxt      = 1'b1;
        st_nxt             = S_DONE;
      end

      // lower-bound walk
      S_LB: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (i_r < fill_w && rd_key < lb_key) begin
            i_nxt = i_r + IW'(1);
          end else if (op_r == skht_pkg::OP_INSERT) begin
            lo_nxt = i_r;
            j_nxt  = fill_w;
            st_nxt = S_INS;
          end else if (!sel_r) begin
            lo_nxt  = i_r;
            i_nxt   = '0;
            sel_nxt = 1'b1;
          end else begin
            span = (i_r > lo_r) ? i_r - lo_r : '0;
            if (span > IW'(skht_pkg::MAX_RUN)) span = IW'(skht_pkg::MAX_RUN);
            n_nxt = span;
            j_nxt = '0;
            if (span == '0) begin
              out_valid_nxt = 1'b1;
              st_nxt        = S_DONE;
            end else begin
              st_nxt = S_EMIT;
            end
          end
        end
      end

      // open a gap at the insert position
      S_INS: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt    = 1'b0;
          wr.key_we = 1'b1;
          wr.hnd_we = 1'b1;
          if (j_r > lo_r) begin
            wr.addr = j_r[AW-1:0];
            j_nxt   = j_r - IW'(1);
          end else begin
            wr.addr  = lo_r[AW-1:0];
            wr.key   = ka_r;
            wr.hnd   = hin_r;
            fill_nxt = fill_r + CW'(1);
            out_nxt.entry_count = fill_w + IW'(1);
            out_valid_nxt = 1'b1;
            st_nxt        = S_DONE;
          end
        end
      end

      // cursor walk
      S_CHECK: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (i_r < fill_w && rd_key < ka_r) begin
            i_nxt = i_r + IW'(1);
          end else begin
            out_nxt.found      = (i_r < fill_w) && (rd_key == ka_r);
            out_nxt.cursor_out = i_r;
            out_valid_nxt      = 1'b1;
            st_nxt             = S_DONE;
          end
        end
      end

      // check no affected key falls below the amount
      S_SCAN_SH: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (i_r < fill_w) begin
            if (rd_key >= ka_r && lt_delta) begin
              out_nxt.status = skht_pkg::ST_BELOW;
              out_valid_nxt  = 1'b1;
              st_nxt         = S_DONE;
            end else begin
              i_nxt = i_r + IW'(1);
            end
          end else begin
            i_nxt  = '0;
            st_nxt = S_APPLY;
          end
        end
      end

      S_APPLY: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (i_r < fill_w) begin
            wr.key_we = rd_key >= ka_r;
            wr.key    = rd_key - sa_r;
            i_nxt     = i_r + IW'(1);
          end else begin
            out_valid_nxt = 1'b1;
            st_nxt        = S_DONE;
          end
        end
      end

      // find delete bounds
      S_SCAN_DL: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if (i_r < fill_w) begin
            if (rd_key >= ka_r && !left_v_r) begin
              left_nxt   = i_r;
              left_v_nxt = 1'b1;
            end
            if (rd_key <= kb_r) begin
              right_nxt   = i_r;
              right_v_nxt = 1'b1;
            end
            i_nxt = i_r + IW'(1);
          end else if (left_v_r && right_v_r && right_r >= left_r) begin
            lo_nxt = left_r;
            i_nxt  = left_r;
            n_nxt  = right_r - left_r + IW'(1);
            st_nxt = S_COMPACT;
          end else begin
            out_valid_nxt = 1'b1;
            st_nxt        = S_DONE;
          end
        end
      end

      // extracted words, one per handshake
      S_EMIT: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt              = 1'b0;
          out_nxt             = '0;
          out_nxt.key_out     = rd_key;
          out_nxt.handle_out  = 32'(rd_hnd);
          out_nxt.entry_count = fill_w - n_r;
          out_nxt.last        = (j_r + IW'(1)) == n_r;
          out_valid_nxt       = 1'b1;
          st_nxt              = S_EWAIT;
        end
      end

      S_EWAIT: begin
        if (out_fire) begin
          if ((j_r + IW'(1)) == n_r) begin
            i_nxt  = lo_r;
            st_nxt = S_COMPACT;
          end else begin
            j_nxt  = j_r + IW'(1);
            st_nxt = S_EMIT;
          end
        end
      end

      // close the removed span
      S_COMPACT: begin
        if (!ph_r) begin
          ph_nxt = 1'b1;
        end else begin
          ph_nxt = 1'b0;
          if ((i_r + n_r) < fill_w) begin
            wr.key_we = 1'b1;
            wr.hnd_we = 1'b1;
            i_nxt     = i_r + IW'(1);
          end else begin
            fill_nxt = fill_r - n_r[CW-1:0];
            if (op_r == skht_pkg::OP_DELETE) begin
              out_nxt.entry_count = fill_w - n_r;
              out_valid_nxt       = 1'b1;
              st_nxt              = S_DONE;
            end else begin
              st_nxt = S_IDLE;
            end
          end
        end
      end

      S_DONE: begin
        if (out_fire) st_nxt = S_IDLE;
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    ka_r      <= ka_nxt;
    kb_r      <= kb_nxt;
    sa_r      <= sa_nxt;
    hin_r     <= hin_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    lo_r      <= lo_nxt;
    n_r       <= n_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    left_v_r  <= left_v_nxt;
    right_v_r <= right_v_nxt;
    sel_r     <= sel_nxt;
    ph_r      <= ph_nxt;
    out_r     <= out_nxt;
  end

  // checks
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_w <= IW'(skht_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |=> $stable(fill_r))
    else $error("fill count moved while idle");

  a_no_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE || st_r == S_DONE) |-> !(wr.key_we || wr.hnd_we))
    else $error("store written outside an operation");

endmodule

`default_nettype wire
